// File: src/cmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared constants, state encoding and control structs for the centered
// moving mean block.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int MAX_WINDOW       = 127;
    localparam int RING_DEPTH       = 128;
    localparam int RING_AW          = $clog2(RING_DEPTH);
    localparam int WIN_W            = 7;
    localparam int POS_W            = 8;
    localparam int CNT_W            = 8;
    localparam int K_W              = POS_W + 1;
    localparam int MAX_RESULTS      = 64;
    localparam int NOUT_W           = $clog2(MAX_RESULTS + 1);
    localparam int SUM_EXTRA        = 8;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(11);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PLAN,
        ST_READ,
        ST_DRAIN,
        ST_DSTART,
        ST_DWAIT,
        ST_PUSH
    } cmm_state_t;

    typedef struct packed {
        logic               wr_en;
        logic               wr_ok;
        logic [RING_AW-1:0] wr_addr;
        logic               clear;
        logic [RING_AW-1:0] rd_addr;
    } cmm_ring_ctl_t;

    typedef struct packed {
        logic push;
        logic mean_valid;
        logic last;
    } cmm_res_flags_t;

endpackage

// File: src/cmm_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_ifs
// Valid/ready channel interfaces: sample input, result output and the
// window length configuration write.
// ----------------------------------------------------------------------------
interface cmm_sample_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_valid;
    logic                           last_sample;

    modport source (output valid, output sample, output sample_valid,
                    output last_sample, input ready);
    modport sink   (input valid, input sample, input sample_valid,
                    input last_sample, output ready);
endinterface

interface cmm_result_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] mean;
    logic                           mean_valid;
    logic                           last_result;

    modport source (output valid, output mean, output mean_valid,
                    output last_result, input ready);
    modport sink   (input valid, input mean, input mean_valid,
                    input last_result, output ready);
endinterface

interface cmm_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// File: src/cmm_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_ring
// Sample ring: value memory with registered read, plus per-entry valid
// flags that reset or a sequence restart clears at once.
// ----------------------------------------------------------------------------
module cmm_ring #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmm_pkg::cmm_ring_ctl_t         ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
    output logic signed [SAMPLE_WIDTH-1:0] rd_data,
    output logic                           rd_ok
);
    import cmm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]          ok_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    logic                           rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[ctl.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg    <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= ok_reg[ctl.rd_addr];
            if (ctl.clear)
            begin
                ok_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                ok_reg[ctl.wr_addr] <= ctl.wr_ok;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_ok   = rd_ok_reg;

endmodule

// File: src/cmm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cmm_div #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    input  logic signed [SAMPLE_WIDTH+cmm_pkg::SUM_EXTRA-1:0]  dividend,
    input  logic [cmm_pkg::CNT_W-1:0]                          divisor,
    output logic                                               done,
    output logic signed [SAMPLE_WIDTH-1:0]                     quotient
);
    import cmm_pkg::*;

    localparam int SUM_W  = SAMPLE_WIDTH + SUM_EXTRA;
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    q_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [CNT_W:0]      trial;
    logic                fits;
    logic [SUM_W-1:0]    mag;
    logic [SUM_W-1:0]    q_signed;

    assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, q_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
        end
    end

    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[SAMPLE_WIDTH-1:0];
    assign done     = done_reg;

endmodule

// File: src/cmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_ctrl
// Sequencer: stores each sample, decides which positions are due, sums
// their windows one ring entry per cycle and runs the divider.
// ----------------------------------------------------------------------------
module cmm_ctrl #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cmm_pkg::WIN_W-1:0]      window_length,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_ok,
    input  logic                           in_last,
    output cmm_pkg::cmm_ring_ctl_t         ring_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] ring_data,
    input  logic                           ring_ok,
    output logic                           div_start,
    output logic signed [SAMPLE_WIDTH+cmm_pkg::SUM_EXTRA-1:0] div_dividend,
    output logic [cmm_pkg::CNT_W-1:0]      div_divisor,
    input  logic                           div_done,
    input  logic signed [SAMPLE_WIDTH-1:0] div_quotient,
    input  logic                           out_free,
    output cmm_pkg::cmm_res_flags_t        res_flags,
    output logic signed [SAMPLE_WIDTH-1:0] res_mean
);
    import cmm_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + SUM_EXTRA;

    cmm_state_t state_reg, state_next;

    logic [RING_AW-1:0]       head_reg;
    logic [POS_W-1:0]         seen_reg;
    logic [POS_W-1:0]         next_pos_reg;
    logic [POS_W-1:0]         pending_reg;
    logic                     long_reg;
    logic                     last_reg;
    logic [NOUT_W-1:0]        nout_reg;
    logic [K_W-1:0]           k_reg;
    logic [K_W-1:0]           k_end_reg;
    logic                     acc_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [SAMPLE_WIDTH-1:0] mean_reg;

    logic [WIN_W-1:0]         win;
    logic [WIN_W-1:0]         left;
    logic [WIN_W-1:0]         right;
    logic [POS_W-1:0]         seen_inc;
    logic [POS_W-1:0]         d;
    logic [POS_W-1:0]         p;
    logic [WIN_W-1:0]         reach_back;
    logic [WIN_W-1:0]         after;
    logic                     due;
    logic                     accept;
    logic [RING_AW-1:0]       newest;

    always_comb
    begin
        win = window_length;
        if (win == '0)
        begin
            win = WIN_W'(1);
        end
        if (win > WIN_W'(MAX_WINDOW))
        begin
            win = WIN_W'(MAX_WINDOW);
        end
    end

    assign left     = win >> 1;
    assign right    = win - left - 1'b1;
    assign seen_inc = seen_reg + 1'b1;
    assign accept   = in_valid && in_ready;
    assign newest   = head_reg - 1'b1;

    assign d          = pending_reg - 1'b1;
    assign p          = seen_reg - 1'b1 - d;
    assign reach_back = (!long_reg && (p < {1'b0, left})) ? p[WIN_W-1:0] : left;
    assign after      = (d < {1'b0, right}) ? d[WIN_W-1:0] : right;

    assign due = (nout_reg < NOUT_W'(MAX_RESULTS)) &&
                 (last_reg ? (pending_reg != '0) : (pending_reg > {1'b0, right}));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = due ? ST_PLAN : ST_IDLE;
            ST_PLAN:   state_next = ST_READ;
            ST_READ:   if (k_reg == k_end_reg) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_DSTART;
            ST_DSTART: state_next = (cnt_reg == '0) ? ST_PUSH : ST_DWAIT;
            ST_DWAIT:  if (div_done) state_next = ST_PUSH;
            ST_PUSH:   if (out_free) state_next = ST_CHECK;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready         = 1'b0;
        ring_ctl.wr_en   = 1'b0;
        ring_ctl.wr_ok   = in_ok;
        ring_ctl.wr_addr = head_reg;
        ring_ctl.clear   = 1'b0;
        ring_ctl.rd_addr = newest - k_reg[RING_AW-1:0];
        div_start        = 1'b0;
        res_flags.push       = 1'b0;
        res_flags.mean_valid = cnt_reg != '0;
        res_flags.last       = last_reg && (pending_reg == POS_W'(1));
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                ring_ctl.wr_en = in_valid;
            end
            ST_CHECK:  ring_ctl.clear = !due && last_reg;
            ST_DSTART: div_start = cnt_reg != '0;
            ST_PUSH:   res_flags.push = out_free;
            default:   ;
        endcase
    end

    assign div_dividend = sum_reg;
    assign div_divisor  = cnt_reg;
    assign res_mean     = mean_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            seen_reg     <= '0;
            next_pos_reg <= '0;
            pending_reg  <= '0;
            long_reg     <= 1'b0;
            last_reg     <= 1'b0;
            nout_reg     <= '0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= state_reg == ST_READ;
            if (accept)
            begin
                head_reg    <= head_reg + 1'b1;
                seen_reg    <= seen_inc;
                pending_reg <= seen_inc - next_pos_reg;
                last_reg    <= in_last;
                nout_reg    <= '0;
                if (seen_inc[POS_W-1] || (seen_inc == '0))
                begin
                    long_reg <= 1'b1;
                end
            end
            if (ring_ctl.clear)
            begin
                head_reg     <= '0;
                seen_reg     <= '0;
                next_pos_reg <= '0;
                long_reg     <= 1'b0;
            end
            if (res_flags.push)
            begin
                pending_reg  <= pending_reg - 1'b1;
                nout_reg     <= nout_reg + 1'b1;
                next_pos_reg <= next_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_PLAN:
            begin
                k_reg     <= {1'b0, d} - K_W'(after);
                k_end_reg <= {1'b0, d} + K_W'(reach_back);
                sum_reg   <= '0;
                cnt_reg   <= '0;
            end
            ST_READ:
            begin
                k_reg <= k_reg + 1'b1;
            end
            ST_DSTART:
            begin
                mean_reg <= '0;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    mean_reg <= div_quotient;
                end
            end
            default: ;
        endcase
        if (acc_reg && ring_ok)
        begin
            sum_reg <= sum_reg + {{(SUM_W-SAMPLE_WIDTH){ring_data[SAMPLE_WIDTH-1]}},
                                  ring_data};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

// File: src/centered_moving_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_mean
// Centered moving mean of gapped samples over a 128-entry ring, with a
// serial divider; the last sample of a sequence flushes pending positions.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  transfer when
//  samples   in   sample, sample_valid, last_sample        valid & ready
//  results   out  mean, mean_valid, last_result            valid & ready
//  cfg       in   window_length                            valid & ready
//
//  Per result: ring reads of the window, one entry per cycle (up to 127),
//  then the serial divider and the push step. samples.ready is high only
//  while the sequencer is idle; an item with no due position returns to
//  idle from the check step. A stalled results channel holds the sequencer
//  at its push step. Reset clears all ring flags at once.
// ----------------------------------------------------------------------------
module centered_moving_mean #(
    parameter int SAMPLE_WIDTH = cmm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    cmm_sample_if.sink          samples,
    cmm_result_if.source        results,
    cmm_cfg_if.sink             cfg
);
    import cmm_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + SUM_EXTRA;

    logic [WIN_W-1:0]               win_len_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_mean_reg;
    logic                           out_mvalid_reg;
    logic                           out_last_reg;
    logic                           out_free;

    cmm_ring_ctl_t                  ring_ctl;
    logic signed [SAMPLE_WIDTH-1:0] ring_data;
    logic                           ring_ok;
    logic                           div_start;
    logic signed [SUM_W-1:0]        div_dividend;
    logic [CNT_W-1:0]               div_divisor;
    logic                           div_done;
    logic signed [SAMPLE_WIDTH-1:0] div_quotient;
    cmm_res_flags_t                 res_flags;
    logic signed [SAMPLE_WIDTH-1:0] res_mean;

    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg   <= WIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                win_len_reg <= cfg.window_length;
            end
            if (res_flags.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_flags.push)
        begin
            out_mean_reg   <= res_mean;
            out_mvalid_reg <= res_flags.mean_valid;
            out_last_reg   <= res_flags.last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.mean        = out_mean_reg;
    assign results.mean_valid  = out_mvalid_reg;
    assign results.last_result = out_last_reg;

    cmm_ring #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .wr_data (samples.sample),
        .rd_data (ring_data),
        .rd_ok   (ring_ok)
    );

    cmm_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    cmm_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (win_len_reg),
        .in_valid      (samples.valid),
        .in_ready      (samples.ready),
        .in_ok         (samples.sample_valid),
        .in_last       (samples.last_sample),
        .ring_ctl      (ring_ctl),
        .ring_data     (ring_data),
        .ring_ok       (ring_ok),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .out_free      (out_free),
        .res_flags     (res_flags),
        .res_mean      (res_mean)
    );

endmodule
